>>> sv/wsli_pkg.sv
// ----------------------------------------------------------------------------
// wsli_pkg: shared types and constants for the LUT waveshaper
// Payload structs for both channels, the queue entry passed from the front
// end to the back end, and the fixed widths of the sample path.
// ----------------------------------------------------------------------------
package wsli_pkg;

  // Item opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Full scale (1.0 in Q1.15) on the unsigned magnitude.
  localparam logic [15:0] MAG_FULL = 16'd32768;

  // Reset value of the drive gain (unity in Q8.8).
  localparam logic [15:0] GAIN_RESET = 16'd256;

  // Queue between front end and back end.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Input transaction.
  typedef struct packed {
    logic               op;
    logic signed [15:0] sample_in;
    logic [9:0]         entry_index;
    logic signed [15:0] entry_value;
  } wsli_in_t;

  // Result transaction.
  typedef struct packed {
    logic signed [15:0] shaped_sample;
    logic               clipped;
  } wsli_out_t;

  // Classified item as it travels through the queue.
  typedef struct packed {
    logic               op;
    logic               wr_ok;
    logic               neg;
    logic               clip;
    logic [15:0]        mag;
    logic [9:0]         entry_index;
    logic signed [15:0] entry_value;
  } wsli_qent_t;

endpackage

>>> sv/waveshaper_lut_interp.sv
// ----------------------------------------------------------------------------
// waveshaper_lut_interp: odd-symmetric waveshaper with interpolated table
// Scales each sample by the drive gain, looks the clamped magnitude up in a
// loadable transfer curve with linear interpolation and restores the sign.
//
// Usage:
//   in_*  : input transactions with valid/stall. op selects between shaping a
//           sample (one result) and writing one table entry (no result).
//   out_* : result transactions with valid/stall.
//   cfg_* : drive gain write with valid/ready; cfg_ready is always high.
//           Write it only while no transaction is in flight.
//   Samples pass the input register, the queue and the back-end stages. One
//   transaction is taken every cycle while in_stall is low; the front end and
//   back end are joined by a 4-entry queue. The back end is a single pipeline
//   that holds still while a result waits on out_stall; the queue then fills
//   and in_stall rises. Table writes take effect for every sample accepted
//   after them. Reset empties the pipeline and sets the gain to unity. The
//   table is not cleared: every entry a sample reads must be written first.
// ----------------------------------------------------------------------------
module waveshaper_lut_interp #(
  parameter int LUT_SIZE = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wsli_pkg::wsli_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wsli_pkg::wsli_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  import wsli_pkg::*;

  logic [15:0] drive_gain_r;
  logic        push;
  wsli_qent_t  push_data;
  logic        q_full;
  logic        q_pop;
  wsli_qent_t  q_data;
  logic        q_valid;

  assign cfg_ready = 1'b1;

  // Drive gain register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      drive_gain_r <= cfg_data;
    end
  end

  wsli_front #(
    .LUT_SIZE (LUT_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .drive_gain (drive_gain_r),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  wsli_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  wsli_back #(
    .LUT_SIZE (LUT_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sv/wsli_ram.sv
// ----------------------------------------------------------------------------
// wsli_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module wsli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while the read enable is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/wsli_front.sv
// ----------------------------------------------------------------------------
// wsli_front: input stage and classifier
// Accepts input transactions, takes the sample magnitude, applies the drive
// gain with clamping and checks write addresses, then pushes to the queue.
// ----------------------------------------------------------------------------
module wsli_front #(
  parameter int LUT_SIZE = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wsli_pkg::wsli_in_t  in_data,
  input  logic [15:0]         drive_gain,
  output logic                push,
  output wsli_pkg::wsli_qent_t push_data,
  input  logic                q_full
);

  import wsli_pkg::*;

  logic               f_valid_r;
  logic               f_op_r;
  logic               f_neg_r;
  logic               f_wr_ok_r;
  logic [15:0]        f_abs_r;
  logic [9:0]         f_idx_r;
  logic signed [15:0] f_val_r;

  logic               accept;
  logic [15:0]        abs_nxt;
  logic               neg_nxt;
  logic               wr_ok_nxt;
  logic [31:0]        gain_prod;
  logic [23:0]        mag_full;
  logic               clip;

  // Stage is blocked only when it holds an item the queue cannot take.
  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid_r && !q_full;

  // Classify the incoming transaction.
  always_comb begin
    abs_nxt   = in_data.sample_in[15] ? (~in_data.sample_in + 16'd1) : in_data.sample_in;
    neg_nxt   = in_data.sample_in[15] && (drive_gain != 16'd0);
    wr_ok_nxt = (32'(in_data.entry_index) < 32'(LUT_SIZE));
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (push) begin
      f_valid_r <= 1'b0;
    end
    if (accept) begin
      f_op_r    <= in_data.op;
      f_neg_r   <= neg_nxt;
      f_wr_ok_r <= wr_ok_nxt;
      f_abs_r   <= abs_nxt;
      f_idx_r   <= in_data.entry_index;
      f_val_r   <= in_data.entry_value;
    end
  end

  // Gain multiply, truncate to Q.15 and clamp to full scale.
  always_comb begin
    gain_prod = f_abs_r * drive_gain;
    mag_full  = gain_prod[31:8];
    clip      = (mag_full >= 24'(MAG_FULL));
    push_data.op          = f_op_r;
    push_data.wr_ok       = f_wr_ok_r;
    push_data.neg         = f_neg_r;
    push_data.clip        = clip;
    push_data.mag         = clip ? MAG_FULL : mag_full[15:0];
    push_data.entry_index = f_idx_r;
    push_data.entry_value = f_val_r;
  end

endmodule

>>> sv/wsli_queue.sv
// ----------------------------------------------------------------------------
// wsli_queue: short FIFO between front end and back end
// Decouples the classifier from the table pipeline so each side can stall.
// ----------------------------------------------------------------------------
module wsli_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wsli_pkg::wsli_qent_t push_data,
  output logic                 full,
  input  logic                 pop,
  output wsli_pkg::wsli_qent_t pop_data,
  output logic                 not_empty
);

  import wsli_pkg::*;

  wsli_qent_t     entries_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic [QAW:0]   count_nxt;

  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = entries_r[rd_ptr_r];

  // Occupancy after this cycle's push and pop.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/wsli_back.sv
// ----------------------------------------------------------------------------
// wsli_back: table pipeline
// Maps the magnitude onto the curve table, performs table writes, reads two
// adjacent entries, interpolates, restores the sign and saturates.
// ----------------------------------------------------------------------------
module wsli_back #(
  parameter int LUT_SIZE = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  wsli_pkg::wsli_qent_t q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wsli_pkg::wsli_out_t  out_data
);

  import wsli_pkg::*;

  localparam int IDX_W = $clog2(LUT_SIZE);
  localparam int POS_W = 15 + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LUT_SIZE - 1);

  logic adv;

  // Stage 1: table position.
  logic               b1_valid_r;
  logic               b1_op_r;
  logic               b1_wr_ok_r;
  logic               b1_neg_r;
  logic               b1_clip_r;
  logic [POS_W-1:0]   b1_pos_r;
  logic [IDX_W-1:0]   b1_waddr_r;
  logic signed [15:0] b1_wdata_r;
  logic [POS_W:0]     pos_full;
  logic [POS_W-1:0]   b1_pos_nxt;
  logic [31:0]        ei_ext;
  logic [IDX_W-1:0]   b1_waddr_nxt;

  // Table access.
  logic [IDX_W-1:0]   idx;
  logic [14:0]        frac;
  logic [IDX_W-1:0]   a_addr;
  logic [IDX_W-1:0]   b_addr;
  logic               ram_we;
  logic [15:0]        a_rd;
  logic [15:0]        b_rd;

  // Stage 2: entries available.
  logic               b2_valid_r;
  logic               b2_neg_r;
  logic               b2_clip_r;
  logic [14:0]        b2_frac_r;
  logic signed [16:0] diff;
  logic signed [15:0] frac_s;
  logic signed [32:0] prod_full;

  // Stage 3: interpolation product.
  logic               b3_valid_r;
  logic               b3_neg_r;
  logic               b3_clip_r;
  logic signed [15:0] b3_a_r;
  logic signed [31:0] b3_prod_r;
  logic signed [31:0] step;
  logic signed [17:0] a_ext;
  logic signed [17:0] y;
  logic signed [17:0] y_signed;
  logic signed [15:0] y_sat;

  // Output register.
  logic               out_valid_r;
  wsli_out_t          out_r;

  // The whole pipeline moves unless a finished result is held by the receiver.
  assign adv       = !out_valid_r || !out_stall;
  assign q_pop     = adv && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Position on the table and write address.
  always_comb begin
    pos_full     = q_data.mag * LAST_IDX;
    b1_pos_nxt   = pos_full[POS_W-1:0];
    ei_ext       = 32'(q_data.entry_index);
    b1_waddr_nxt = ei_ext[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (adv) begin
      b1_valid_r <= q_valid;
    end
    if (adv) begin
      b1_op_r    <= q_data.op;
      b1_wr_ok_r <= q_data.wr_ok;
      b1_neg_r   <= q_data.neg;
      b1_clip_r  <= q_data.clip;
      b1_pos_r   <= b1_pos_nxt;
      b1_waddr_r <= b1_waddr_nxt;
      b1_wdata_r <= q_data.entry_value;
    end
  end

  // Index and fraction; at full scale both reads hit the last entry.
  always_comb begin
    idx    = b1_pos_r[POS_W-1:15];
    frac   = b1_pos_r[14:0];
    a_addr = idx;
    b_addr = (idx == LAST_IDX) ? idx : idx + IDX_W'(1);
    ram_we = adv && b1_valid_r && (b1_op_r == OP_WRITE) && b1_wr_ok_r;
  end

  // Two copies of the curve table, one per adjacent entry.
  wsli_ram #(
    .WIDTH (16),
    .DEPTH (LUT_SIZE)
  ) u_ram_a (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (b1_waddr_r),
    .wr_data (b1_wdata_r),
    .re      (adv),
    .rd_addr (a_addr),
    .rd_data (a_rd)
  );

  wsli_ram #(
    .WIDTH (16),
    .DEPTH (LUT_SIZE)
  ) u_ram_b (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (b1_waddr_r),
    .wr_data (b1_wdata_r),
    .re      (adv),
    .rd_addr (b_addr),
    .rd_data (b_rd)
  );

  // Only sample transactions continue past the table access.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else if (adv) begin
      b2_valid_r <= b1_valid_r && (b1_op_r == OP_SAMPLE);
    end
    if (adv) begin
      b2_neg_r  <= b1_neg_r;
      b2_clip_r <= b1_clip_r;
      b2_frac_r <= frac;
    end
  end

  // Fraction times the slope between the two entries.
  always_comb begin
    diff      = 17'($signed(b_rd)) - 17'($signed(a_rd));
    frac_s    = $signed({1'b0, b2_frac_r});
    prod_full = frac_s * diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_valid_r <= 1'b0;
    end else if (adv) begin
      b3_valid_r <= b2_valid_r;
    end
    if (adv) begin
      b3_neg_r  <= b2_neg_r;
      b3_clip_r <= b2_clip_r;
      b3_a_r    <= $signed(a_rd);
      b3_prod_r <= prod_full[31:0];
    end
  end

  // Floor shift, add the base entry, restore the sign and saturate.
  always_comb begin
    step     = b3_prod_r >>> 15;
    a_ext    = 18'(b3_a_r);
    y        = a_ext + $signed(step[17:0]);
    y_signed = b3_neg_r ? -y : y;
    if (y_signed > 18'sd32767) begin
      y_sat = 16'sd32767;
    end else if (y_signed < -18'sd32768) begin
      y_sat = -16'sd32768;
    end else begin
      y_sat = y_signed[15:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b3_valid_r;
    end
    if (adv) begin
      out_r.shaped_sample <= y_sat;
      out_r.clipped       <= b3_clip_r;
    end
  end

endmodule
